### sv/ldp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ldp_pkg;

  // Request codes carried in the slave-side tuser.
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_DELETE     = 3'd4;
  localparam logic [2:0] REQ_CLEAR      = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // What a request turns into once it has been checked against the state.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_TAKE_FRONT,
    OP_TAKE_BACK,
    OP_UNLINK,
    OP_CLEAR,
    OP_FAIL
  } op_t;

endpackage

`default_nettype wire

### sv/ldp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ldp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/linked_deque_pool.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Group                 Contents
// s_axis   in   s_tvalid/s_tready     tuser: req_type; tdata: data_in, node_handle
// m_axis   out  m_tvalid/m_tready     tuser: ok; tdata: data_out, new_handle,
//                                     count_after, is_empty
//
// A request runs through IDLE, EXEC and RESP: the beat is taken and the node's
// links and payload are read, then the neighbours are rewritten, then the
// result is loaded into the output register. The link memories have
// registered reads. A new beat is taken while the previous result still waits
// on m_tready; the result stage holds until the output register is free.
// Reset (rst, synchronous) empties the pool; the memories are not cleared.

module linked_deque_pool #(
  parameter int POOL_DEPTH = 16,
  parameter int WORD_BITS  = 32,
  localparam int HW        = $clog2(POOL_DEPTH),
  localparam int CW        = $clog2(POOL_DEPTH + 1),
  localparam int IN_BITS   = WORD_BITS + HW,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = WORD_BITS + HW + CW + 1,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [2:0]       s_tuser,  // req_type
  input  wire logic [IN_W-1:0]  s_tdata,  // data_in, node_handle, zero fill
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic                  m_tuser,  // ok
  output logic      [OUT_W-1:0] m_tdata   // data_out, new_handle, count_after,
                                          // is_empty, zero fill
);

  ldp_pkg::state_t state, state_next;
  ldp_pkg::op_t    op, op_next;

  logic [POOL_DEPTH-1:0] live;
  logic [HW-1:0]         head, tail;
  logic [CW-1:0]         count;
  logic [HW-1:0]         slot;
  logic [HW-1:0]         node;

  logic                  res_ok;
  logic [WORD_BITS-1:0]  res_data;
  logic [HW-1:0]         res_handle;

  logic [WORD_BITS-1:0]  data_in;
  logic [HW-1:0]         node_handle;
  logic                  accept, exec_en, resp_load;

  logic [POOL_DEPTH-1:0] free_vec, low_free;
  logic [HW-1:0]         free_idx;
  logic                  full;
  logic                  handle_ok;
  logic [HW-1:0]         rd_addr;

  logic                  next_we, prev_we, pay_we;
  logic [HW-1:0]         next_waddr, prev_waddr, next_wdata, prev_wdata;
  logic [HW-1:0]         rd_next, rd_prev;
  logic [WORD_BITS-1:0]  rd_payload;

  assign data_in     = s_tdata[WORD_BITS-1:0];
  assign node_handle = s_tdata[WORD_BITS +: HW];

  // Lowest free node: isolate the lowest set bit of the free vector.
  always_comb begin
    free_vec = ~live;
    low_free = free_vec & (~free_vec + POOL_DEPTH'(1));
    free_idx = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (low_free[i]) begin
        free_idx = free_idx | HW'(i);
      end
    end
    full = &live;
  end

  assign handle_ok = ({1'b0, node_handle} < (HW + 1)'(POOL_DEPTH)) &&
                     live[node_handle] && (count != '0);

  // Classify the request against the current state.
  always_comb begin
    op_next = ldp_pkg::OP_FAIL;
    rd_addr = node_handle;
    unique case (s_tuser)
      ldp_pkg::REQ_PUSH_FRONT: if (!full) op_next = ldp_pkg::OP_PUSH_FRONT;
      ldp_pkg::REQ_PUSH_BACK:  if (!full) op_next = ldp_pkg::OP_PUSH_BACK;
      ldp_pkg::REQ_POP_FRONT: begin
        rd_addr = head;
        if (count != '0) op_next = ldp_pkg::OP_TAKE_FRONT;
      end
      ldp_pkg::REQ_POP_BACK: begin
        rd_addr = tail;
        if (count != '0) op_next = ldp_pkg::OP_TAKE_BACK;
      end
      ldp_pkg::REQ_DELETE: begin
        if (handle_ok) begin
          if (node_handle == head) begin
            op_next = ldp_pkg::OP_TAKE_FRONT;
          end else if (node_handle == tail) begin
            op_next = ldp_pkg::OP_TAKE_BACK;
          end else begin
            op_next = ldp_pkg::OP_UNLINK;
          end
        end
      end
      ldp_pkg::REQ_CLEAR: op_next = ldp_pkg::OP_CLEAR;
      default:            op_next = ldp_pkg::OP_FAIL;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ldp_pkg::ST_IDLE: if (s_tvalid) state_next = ldp_pkg::ST_EXEC;
      ldp_pkg::ST_EXEC: state_next = ldp_pkg::ST_RESP;
      ldp_pkg::ST_RESP: if (!m_tvalid || m_tready) state_next = ldp_pkg::ST_IDLE;
      default:          state_next = ldp_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_tready  = 1'b0;
    exec_en   = 1'b0;
    resp_load = 1'b0;
    unique case (state)
      ldp_pkg::ST_IDLE: s_tready  = 1'b1;
      ldp_pkg::ST_EXEC: exec_en   = 1'b1;
      ldp_pkg::ST_RESP: resp_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // Memory writes. A push writes the new node as the beat is taken; the
  // neighbour fix-ups follow in the execute cycle, when the read data is back.
  always_comb begin
    next_we    = 1'b0;
    prev_we    = 1'b0;
    pay_we     = 1'b0;
    next_waddr = free_idx;
    prev_waddr = free_idx;
    next_wdata = free_idx;
    prev_wdata = free_idx;
    if (accept && (op_next == ldp_pkg::OP_PUSH_FRONT ||
                   op_next == ldp_pkg::OP_PUSH_BACK)) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      pay_we  = 1'b1;
      if (count != '0 && op_next == ldp_pkg::OP_PUSH_FRONT) next_wdata = head;
      if (count != '0 && op_next == ldp_pkg::OP_PUSH_BACK)  prev_wdata = tail;
    end else if (exec_en) begin
      case (op)
        ldp_pkg::OP_PUSH_FRONT: begin
          prev_we    = (count != '0);
          prev_waddr = head;
          prev_wdata = slot;
        end
        ldp_pkg::OP_PUSH_BACK: begin
          next_we    = (count != '0);
          next_waddr = tail;
          next_wdata = slot;
        end
        ldp_pkg::OP_TAKE_FRONT: begin
          prev_we    = (count > CW'(1));
          prev_waddr = rd_next;
          prev_wdata = rd_next;
        end
        ldp_pkg::OP_TAKE_BACK: begin
          next_we    = (count > CW'(1));
          next_waddr = rd_prev;
          next_wdata = rd_prev;
        end
        ldp_pkg::OP_UNLINK: begin
          next_we    = 1'b1;
          next_waddr = rd_prev;
          next_wdata = rd_next;
          prev_we    = 1'b1;
          prev_waddr = rd_next;
          prev_wdata = rd_prev;
        end
        default: ;
      endcase
    end
  end

  ldp_ram #(.WIDTH(HW), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (rd_addr),
    .rdata (rd_next)
  );

  ldp_ram #(.WIDTH(HW), .DEPTH(POOL_DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (rd_addr),
    .rdata (rd_prev)
  );

  ldp_ram #(.WIDTH(WORD_BITS), .DEPTH(POOL_DEPTH)) u_payload_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (free_idx),
    .wdata (data_in),
    .raddr (rd_addr),
    .rdata (rd_payload)
  );

  // Sequencer and list registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ldp_pkg::ST_IDLE;
      live     <= '0;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_en) begin
        case (op) inside
          ldp_pkg::OP_PUSH_FRONT, ldp_pkg::OP_PUSH_BACK: begin
            live[slot] <= 1'b1;
            count      <= count + CW'(1);
            if (count == '0) begin
              head <= slot;
              tail <= slot;
            end else if (op == ldp_pkg::OP_PUSH_FRONT) begin
              head <= slot;
            end else begin
              tail <= slot;
            end
          end
          ldp_pkg::OP_TAKE_FRONT, ldp_pkg::OP_TAKE_BACK: begin
            live[node] <= 1'b0;
            count      <= count - CW'(1);
            if (count > CW'(1)) begin
              if (op == ldp_pkg::OP_TAKE_FRONT) head <= rd_next;
              else tail <= rd_prev;
            end else begin
              head <= '0;
              tail <= '0;
            end
          end
          ldp_pkg::OP_UNLINK: begin
            live[node] <= 1'b0;
            count      <= count - CW'(1);
          end
          ldp_pkg::OP_CLEAR: begin
            live  <= '0;
            head  <= '0;
            tail  <= '0;
            count <= '0;
          end
          default: ;
        endcase
      end
      if (resp_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Beat payload and result holding registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= op_next;
      slot <= free_idx;
      node <= rd_addr;
    end
    if (exec_en) begin
      res_ok     <= (op != ldp_pkg::OP_FAIL);
      res_data   <= '0;
      res_handle <= '0;
      case (op) inside
        ldp_pkg::OP_PUSH_FRONT, ldp_pkg::OP_PUSH_BACK: res_handle <= slot;
        ldp_pkg::OP_TAKE_FRONT, ldp_pkg::OP_TAKE_BACK, ldp_pkg::OP_UNLINK:
          res_data <= rd_payload;
        default: ;
      endcase
    end
    if (resp_load) begin
      m_tuser <= res_ok;
      m_tdata <= OUT_W'({(count == '0), count, res_handle, res_data});
    end
  end

endmodule

`default_nettype wire
